// File: rtl/core/dll_pkg.sv
// Shared types, constants and helpers for the doubly linked list engine.
// No dependencies; every module of the block imports this package.
package dll_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LINK_W   = $clog2(CAPACITY + 1);

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);
  localparam logic [LINK_W-1:0] LAST_STEP = LINK_W'(CAPACITY - 1);

  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_REMOVE     = 3'd2,
    FUNC_LIST_FWD   = 3'd3,
    FUNC_LIST_BWD   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    KIND_DONE     = 3'd0,
    KIND_ELEM     = 3'd1,
    KIND_EMPTY    = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_NOTFOUND = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_FIX,
    S_WALK,
    S_UNLINK_P,
    S_UNLINK_N,
    S_LIST,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] out_value;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [31:0]       value;
    logic [LINK_W-1:0] next_link;
    logic [LINK_W-1:0] prev_link;
  } node_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             value_we;
    logic             next_we;
    logic             prev_we;
    logic [IDX_W-1:0] wr_addr;
    node_t            wr_node;
  } mem_req_t;

  function automatic logic is_node(input logic [LINK_W-1:0] link);
    return link < NULL_LINK;
  endfunction

  function automatic logic [LINK_W-1:0] first_free(input logic [CAPACITY-1:0] occ);
    logic [LINK_W-1:0] idx;
    idx = NULL_LINK;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!occ[i]) idx = LINK_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/doubly_linked_list_engine.sv
// Doubly linked list engine: top level with command sequencer and response register.
// Depends on dll_pkg and dll_node_mem.
//
// Usage: commands enter on cmd (cmd_valid / cmd_stall), one at a time; results leave
// on rsp (rsp_valid / rsp_stall), each word registered. Every command gives at least
// one result word; the final word of a command carries last.
// Sequence after a command is accepted:
//   push: write the new node, then relink the old end node of a non-empty list.
//   remove: walks from the head, one node per cycle, set by the single read port
//   of the node store (at most CAPACITY nodes); on a match it unlinks the node.
//   list: fetch the end node, then one element word per cycle unless rsp_stall.
//   empty list, store full and unknown codes: only the status word.
// cmd_stall is high while a command is in progress; a new command may be taken while
// the previous final word still waits in the response register.
// A stalled response holds its word; a list walk pauses on the stall and resumes.
// Reset (synchronous, active high) empties the list: head and tail go
// to the null link and the occupancy map clears; node contents are left as they are.
module doubly_linked_list_engine import dll_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t            state, state_next;
  func_t             cmd_func;
  logic [31:0]       cmd_value;
  logic [LINK_W-1:0] cur, steps, link_p, link_n;
  logic [LINK_W-1:0] head_link, tail_link, free_link;
  logic [CAPACITY-1:0] occupied;
  kind_t             res_kind;

  mem_req_t          req;
  node_t             rdata;
  logic              accept, slot_free, full, at_front, match, last_step;
  logic [LINK_W-1:0] walk_next, list_next, other_end;
  logic              walk_done, list_last;
  func_t             in_func;
  logic              rsp_load;
  rsp_t              rsp_word;

  dll_node_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign in_func   = func_t'(cmd.func);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign full      = !is_node(free_link);
  assign at_front  = (cmd_func == FUNC_PUSH_FRONT);
  assign other_end = at_front ? head_link : tail_link;
  assign match     = (rdata.value == cmd_value);
  assign last_step = (steps == LAST_STEP);
  assign walk_next = rdata.next_link;
  assign walk_done = !is_node(walk_next) || last_step;
  assign list_next = (cmd_func == FUNC_LIST_BWD) ? rdata.prev_link : rdata.next_link;
  assign list_last = !is_node(list_next) || last_step;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: state_next = full ? S_EMIT : S_PUSH;
            FUNC_REMOVE:   state_next = is_node(head_link) ? S_WALK : S_EMIT;
            FUNC_LIST_FWD: state_next = is_node(head_link) ? S_LIST : S_EMIT;
            FUNC_LIST_BWD: state_next = is_node(tail_link) ? S_LIST : S_EMIT;
            default:       state_next = S_EMIT;
          endcase
        end
      end
      S_PUSH:     state_next = is_node(other_end) ? S_FIX : S_EMIT;
      S_FIX:      state_next = S_EMIT;
      S_WALK: begin
        if (match) state_next = S_UNLINK_P;
        else if (walk_done) state_next = S_EMIT;
      end
      S_UNLINK_P: state_next = S_UNLINK_N;
      S_UNLINK_N: state_next = S_EMIT;
      S_LIST:     if (slot_free && list_last) state_next = S_IDLE;
      S_EMIT:     if (slot_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req      = '0;
    rsp_load = 1'b0;
    rsp_word = '0;
    case (state)
      S_IDLE: begin
        req.rd_en   = accept;
        req.rd_addr = (in_func == FUNC_LIST_BWD) ? tail_link[IDX_W-1:0]
                                                 : head_link[IDX_W-1:0];
      end
      S_PUSH: begin
        req.value_we          = 1'b1;
        req.next_we           = 1'b1;
        req.prev_we           = 1'b1;
        req.wr_addr           = cur[IDX_W-1:0];
        req.wr_node.value     = cmd_value;
        req.wr_node.next_link = at_front ? head_link : NULL_LINK;
        req.wr_node.prev_link = at_front ? NULL_LINK : tail_link;
      end
      S_FIX: begin
        req.wr_addr           = link_n[IDX_W-1:0];
        req.prev_we           = at_front;
        req.next_we           = !at_front;
        req.wr_node.next_link = cur;
        req.wr_node.prev_link = cur;
      end
      S_WALK: begin
        req.rd_en   = !match && !walk_done;
        req.rd_addr = walk_next[IDX_W-1:0];
      end
      S_UNLINK_P: begin
        req.next_we           = is_node(link_p);
        req.wr_addr           = link_p[IDX_W-1:0];
        req.wr_node.next_link = link_n;
      end
      S_UNLINK_N: begin
        req.prev_we           = is_node(link_n);
        req.wr_addr           = link_n[IDX_W-1:0];
        req.wr_node.prev_link = link_p;
      end
      S_LIST: begin
        rsp_load           = slot_free;
        rsp_word.kind      = KIND_ELEM;
        rsp_word.out_value = rdata.value;
        rsp_word.last      = list_last;
        req.rd_en          = slot_free && !list_last;
        req.rd_addr        = list_next[IDX_W-1:0];
      end
      S_EMIT: begin
        rsp_load      = slot_free;
        rsp_word.kind = res_kind;
        rsp_word.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_link <= NULL_LINK;
      tail_link <= NULL_LINK;
      occupied  <= '0;
      free_link <= '0;
    end else begin
      state     <= state_next;
      free_link <= first_free(occupied);
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_func  <= in_func;
            cmd_value <= cmd.item_value;
            steps     <= '0;
            case (in_func)
              FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                cur      <= free_link;
                res_kind <= full ? KIND_FULL : KIND_DONE;
              end
              FUNC_REMOVE: begin
                cur      <= head_link;
                res_kind <= KIND_NOTFOUND;
              end
              FUNC_LIST_FWD: begin
                cur      <= head_link;
                res_kind <= KIND_EMPTY;
              end
              FUNC_LIST_BWD: begin
                cur      <= tail_link;
                res_kind <= KIND_EMPTY;
              end
              default: res_kind <= KIND_DONE;
            endcase
          end
        end
        S_PUSH: begin
          occupied[cur[IDX_W-1:0]] <= 1'b1;
          link_n <= other_end;
          if (at_front) begin
            head_link <= cur;
            if (!is_node(tail_link)) tail_link <= cur;
          end else begin
            tail_link <= cur;
            if (!is_node(head_link)) head_link <= cur;
          end
        end
        S_WALK: begin
          if (match) begin
            link_p <= rdata.prev_link;
            link_n <= rdata.next_link;
          end else begin
            cur   <= walk_next;
            steps <= steps + LINK_W'(1);
          end
        end
        S_UNLINK_P: begin
          if (!is_node(link_p)) head_link <= link_n;
          if (!is_node(link_n)) tail_link <= link_p;
        end
        S_UNLINK_N: begin
          occupied[cur[IDX_W-1:0]] <= 1'b0;
          res_kind <= KIND_DONE;
        end
        S_LIST: begin
          if (slot_free) begin
            cur   <= list_next;
            steps <= steps + LINK_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) rsp <= rsp_word;
  end

  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    is_node(head_link) == is_node(tail_link))
    else $error("head and tail disagree on list emptiness");

  a_empty_map: assert property (@(posedge clk) disable iff (rst)
    (occupied == '0) |-> !is_node(head_link))
    else $error("list has a head but no node is occupied");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK || state == S_LIST) |-> (steps < NULL_LINK))
    else $error("walk went past the node count");

  a_single_word: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind != KIND_ELEM) |-> (rsp.out_value == 0 && rsp.last))
    else $error("status word carries a value or lacks last");

endmodule

// File: rtl/core/dll_node_mem.sv
// Node store: value, successor and predecessor link per node.
// One write port with per-field enables, one registered read port. Uses dll_pkg.
module dll_node_mem import dll_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output node_t    rdata
);

  node_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.value_we) mem[req.wr_addr].value     <= req.wr_node.value;
    if (req.next_we)  mem[req.wr_addr].next_link <= req.wr_node.next_link;
    if (req.prev_we)  mem[req.wr_addr].prev_link <= req.wr_node.prev_link;
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) rdata <= mem[req.rd_addr];
  end

endmodule
